// File: hw/rtl/playfair_digraph_cipher_macros.svh
// Assertion macros shared by the playfair digraph cipher RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside of reset.
`define PFC_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("pfc assertion failed");
// Next-cycle implication, checked outside of reset.
`define PFC_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("pfc assertion failed");
`else
`define PFC_ASSERT_IMP(label, clk, rst_n, pre, post)
`define PFC_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: hw/rtl/pfc_pkg.sv
// Shared types, codes and constants of the playfair digraph cipher.
// No dependencies; used by every module of the block.
package pfc_pkg;

  localparam int SYM_W = 16;
  localparam int IDX_W = 5;
  localparam int CMD_W = 2;

  localparam int ROWS_DEFAULT = 4;
  localparam int COLS_DEFAULT = 8;

  localparam logic [SYM_W-1:0] FILLER_RESET = 16'h0420;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_CALC,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
    logic             not_found;
  } out_item_t;

endpackage

// File: hw/rtl/pfc_lane.sv
// One table row: holds the row's entries and finds the first column
// matching each symbol of the pair. Depends on pfc_pkg.
module pfc_lane #(
  parameter int COLS    = pfc_pkg::COLS_DEFAULT,
  parameter int ROW_IDX = 0
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [pfc_pkg::IDX_W-1:0]  wr_index_i,
  input  logic [pfc_pkg::SYM_W-1:0]  wr_data_i,
  input  logic [pfc_pkg::SYM_W-1:0]  sym_a_i,
  input  logic [pfc_pkg::SYM_W-1:0]  sym_b_i,
  output logic                       hit_a_o,
  output logic                       hit_b_o,
  output logic [$clog2(COLS)-1:0]    col_a_o,
  output logic [$clog2(COLS)-1:0]    col_b_o
);

  localparam int CW = $clog2(COLS);

  logic [pfc_pkg::SYM_W-1:0] entry_q [COLS];

  // Each cell takes a load aimed at its own row-major position.
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < COLS; c++) begin
      if (wr_en_i && (int'(wr_index_i) == ROW_IDX * COLS + c)) begin
        entry_q[c] <= wr_data_i;
      end
    end
  end

  // Scan from the right so that the leftmost match wins.
  always_comb begin
    hit_a_o = 1'b0;
    hit_b_o = 1'b0;
    col_a_o = '0;
    col_b_o = '0;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (entry_q[c] == sym_a_i) begin
        hit_a_o = 1'b1;
        col_a_o = CW'(c);
      end
      if (entry_q[c] == sym_b_i) begin
        hit_b_o = 1'b1;
        col_b_o = CW'(c);
      end
    end
  end

endmodule

// File: hw/rtl/pfc_merge.sv
// Combines the lane results: the last row with a match gives the position.
// Depends on pfc_pkg for default sizes only.
module pfc_merge #(
  parameter int ROWS = pfc_pkg::ROWS_DEFAULT,
  parameter int COLS = pfc_pkg::COLS_DEFAULT
) (
  input  logic [ROWS-1:0]                   hit_a_i,
  input  logic [ROWS-1:0]                   hit_b_i,
  input  logic [ROWS-1:0][$clog2(COLS)-1:0] col_a_i,
  input  logic [ROWS-1:0][$clog2(COLS)-1:0] col_b_i,
  output logic                              found_a_o,
  output logic                              found_b_o,
  output logic [$clog2(ROWS)-1:0]           row_a_o,
  output logic [$clog2(ROWS)-1:0]           row_b_o,
  output logic [$clog2(COLS)-1:0]           col_a_o,
  output logic [$clog2(COLS)-1:0]           col_b_o
);

  localparam int RW = $clog2(ROWS);

  // A later row replaces an earlier one.
  always_comb begin
    found_a_o = 1'b0;
    found_b_o = 1'b0;
    row_a_o   = '0;
    row_b_o   = '0;
    col_a_o   = '0;
    col_b_o   = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (hit_a_i[r]) begin
        found_a_o = 1'b1;
        row_a_o   = RW'(r);
        col_a_o   = col_a_i[r];
      end
      if (hit_b_i[r]) begin
        found_b_o = 1'b1;
        row_b_o   = RW'(r);
        col_b_o   = col_b_i[r];
      end
    end
  end

endmodule

// File: hw/rtl/pfc_table_ram.sv
// Copy of the symbol table with one write port and two registered read
// ports, used to fetch the output symbols. Depends on pfc_pkg.
module pfc_table_ram #(
  parameter int DEPTH = pfc_pkg::ROWS_DEFAULT * pfc_pkg::COLS_DEFAULT
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr_i,
  input  logic [pfc_pkg::SYM_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_a_i,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr_b_i,
  output logic [pfc_pkg::SYM_W-1:0] rd_data_a_o,
  output logic [pfc_pkg::SYM_W-1:0] rd_data_b_o
);

  logic [pfc_pkg::SYM_W-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_a_o <= mem_q[rd_addr_a_i];
      rd_data_b_o <= mem_q[rd_addr_b_i];
    end
  end

endmodule

// File: hw/rtl/playfair_digraph_cipher.sv
// Top level of the playfair digraph cipher on a ROWS by COLS symbol table.
// Depends on pfc_pkg, pfc_lane, pfc_merge, pfc_table_ram and the macro header.
//
// Channel   Direction  Handshake                     Moves
// s_axis    in         s_axis_tvalid/s_axis_tready   load or cipher request
// m_axis    out        m_axis_tvalid/m_axis_tready   one result symbol
// cfg       in         cfg_valid_i/cfg_ready_o       filler symbol write
//
// A load request is written while the block stays idle; a cipher pair passes
// from acceptance through a locate state (row lanes compare, merge picks the
// row), an address state (table read port) and a result state before its
// results sit in the output queue, and no new request is taken until it is done.
// Reset clears control state only; the table is undefined until loaded.
// Results wait in a four-entry queue; a pair holds in its result cycle
// until two queue slots are free, while the input side stays stalled.
module playfair_digraph_cipher #(
  parameter int ROWS = pfc_pkg::ROWS_DEFAULT,
  parameter int COLS = pfc_pkg::COLS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] entry_index, [20:5] first_symbol, [36:21] second_symbol, [39:37] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_symbol
  output logic [15:0] m_axis_tdata,
  // last_of_pair
  output logic        m_axis_tlast,
  // [0] not_found
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  `include "playfair_digraph_cipher_macros.svh"

  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLS);
  localparam int DEPTH      = ROWS * COLS;
  localparam int AW         = $clog2(DEPTH);
  localparam int FIFO_DEPTH = 4;
  localparam int PW         = $clog2(FIFO_DEPTH);
  localparam int NW         = $clog2(FIFO_DEPTH + 1);

  // Wrap-around steps along a row or a column.
  function automatic logic [CW-1:0] col_step(logic [CW-1:0] c, logic dec);
    if (dec) begin
      return (c == '0) ? CW'(COLS - 1) : c - 1'b1;
    end
    return (c == CW'(COLS - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [RW-1:0] row_step(logic [RW-1:0] r, logic dec);
    if (dec) begin
      return (r == '0) ? RW'(ROWS - 1) : r - 1'b1;
    end
    return (r == RW'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

  // Input request fields.
  pfc_pkg::cmd_e                in_cmd;
  logic [pfc_pkg::IDX_W-1:0]    in_idx;
  logic [pfc_pkg::SYM_W-1:0]    in_first;
  logic [pfc_pkg::SYM_W-1:0]    in_second;
  logic                         in_accept;
  logic                         load_en;
  logic                         cipher_start;

  assign in_cmd    = pfc_pkg::cmd_e'(s_axis_tuser);
  assign in_idx    = s_axis_tdata[4:0];
  assign in_first  = s_axis_tdata[20:5];
  assign in_second = s_axis_tdata[36:21];

  pfc_pkg::state_e state_q, state_d;

  assign s_axis_tready = (state_q == pfc_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign load_en       = in_accept && (in_cmd == pfc_pkg::CMD_LOAD)
                         && (int'(in_idx) < DEPTH);
  assign cipher_start  = in_accept && ((in_cmd == pfc_pkg::CMD_ENCRYPT)
                         || (in_cmd == pfc_pkg::CMD_DECRYPT));

  // Filler register.
  logic [pfc_pkg::SYM_W-1:0] filler_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filler_q <= pfc_pkg::FILLER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      filler_q <= cfg_data_i;
    end
  end

  // Pair registers, captured when a cipher request is accepted.
  logic [pfc_pkg::SYM_W-1:0] sym_a_q, sym_b_q;
  logic                      dec_q;

  always_ff @(posedge clk_i) begin
    if (cipher_start) begin
      sym_a_q <= in_first;
      sym_b_q <= in_second;
      dec_q   <= (in_cmd == pfc_pkg::CMD_DECRYPT);
    end
  end

  // Row lanes.
  logic [ROWS-1:0]         lane_hit_a, lane_hit_b;
  logic [ROWS-1:0][CW-1:0] lane_col_a, lane_col_b;

  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    pfc_lane #(
      .COLS    (COLS),
      .ROW_IDX (r)
    ) u_lane (
      .clk_i      (clk_i),
      .wr_en_i    (load_en),
      .wr_index_i (in_idx),
      .wr_data_i  (in_first),
      .sym_a_i    (sym_a_q),
      .sym_b_i    (sym_b_q),
      .hit_a_o    (lane_hit_a[r]),
      .hit_b_o    (lane_hit_b[r]),
      .col_a_o    (lane_col_a[r]),
      .col_b_o    (lane_col_b[r])
    );
  end

  // Merge stage and its position registers.
  logic          mrg_found_a, mrg_found_b;
  logic [RW-1:0] mrg_row_a, mrg_row_b;
  logic [CW-1:0] mrg_col_a, mrg_col_b;

  pfc_merge #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_merge (
    .hit_a_i   (lane_hit_a),
    .hit_b_i   (lane_hit_b),
    .col_a_i   (lane_col_a),
    .col_b_i   (lane_col_b),
    .found_a_o (mrg_found_a),
    .found_b_o (mrg_found_b),
    .row_a_o   (mrg_row_a),
    .row_b_o   (mrg_row_b),
    .col_a_o   (mrg_col_a),
    .col_b_o   (mrg_col_b)
  );

  logic          found_q;
  logic [RW-1:0] row_a_q, row_b_q;
  logic [CW-1:0] col_a_q, col_b_q;

  always_ff @(posedge clk_i) begin
    if (state_q == pfc_pkg::ST_LOCATE) begin
      found_q <= mrg_found_a && mrg_found_b;
      row_a_q <= mrg_row_a;
      row_b_q <= mrg_row_b;
      col_a_q <= mrg_col_a;
      col_b_q <= mrg_col_b;
    end
  end

  // Output positions from the playfair rules.
  logic [RW-1:0] out_row_a, out_row_b;
  logic [CW-1:0] out_col_a, out_col_b;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  always_comb begin
    out_row_a = row_a_q;
    out_row_b = row_b_q;
    out_col_a = col_a_q;
    out_col_b = col_b_q;
    if (row_a_q == row_b_q) begin
      out_col_a = col_step(col_a_q, dec_q);
      out_col_b = col_step(col_b_q, dec_q);
    end else if (col_a_q == col_b_q) begin
      out_row_a = row_step(row_a_q, dec_q);
      out_row_b = row_step(row_b_q, dec_q);
    end else begin
      out_col_a = col_b_q;
      out_col_b = col_a_q;
    end
  end

  assign rd_addr_a = AW'(int'(out_row_a) * COLS + int'(out_col_a));
  assign rd_addr_b = AW'(int'(out_row_b) * COLS + int'(out_col_b));

  // Table copy for fetching the output symbols.
  logic [pfc_pkg::SYM_W-1:0] rd_sym_a, rd_sym_b;

  pfc_table_ram #(
    .DEPTH (DEPTH)
  ) u_table_ram (
    .clk_i       (clk_i),
    .wr_en_i     (load_en),
    .wr_addr_i   (AW'(in_idx)),
    .wr_data_i   (in_first),
    .rd_en_i     (state_q == pfc_pkg::ST_CALC),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_sym_a),
    .rd_data_b_o (rd_sym_b)
  );

  // Result items: decrypt drops filler symbols, not-found gives one flag item.
  pfc_pkg::out_item_t item0, item1;
  logic [1:0]         item_n;
  logic               keep_a, keep_b;

  always_comb begin
    keep_a = !(dec_q && (rd_sym_a == filler_q));
    keep_b = !(dec_q && (rd_sym_b == filler_q));
    item1  = '{sym: rd_sym_b, last: 1'b1, not_found: 1'b0};
    if (!found_q) begin
      item0  = '{sym: '0, last: 1'b1, not_found: 1'b1};
      item_n = 2'd1;
    end else begin
      item_n = 2'(keep_a) + 2'(keep_b);
      item0  = '{sym: (keep_a ? rd_sym_a : rd_sym_b), last: (item_n == 2'd1),
                 not_found: 1'b0};
    end
  end

  // Output queue.
  pfc_pkg::out_item_t fifo_q [FIFO_DEPTH];
  logic [PW-1:0]      wptr_q, rptr_q;
  logic [NW-1:0]      count_q;
  logic               push;
  logic [1:0]         push_n;
  logic               pop;

  assign push   = (state_q == pfc_pkg::ST_RESULT) && (count_q <= NW'(FIFO_DEPTH - 2));
  assign push_n = push ? item_n : 2'd0;
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wptr_q] <= item0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wptr_q + 1'b1] <= item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PW'(push_n);
      rptr_q  <= rptr_q + PW'(pop);
      count_q <= count_q + NW'(push_n) - NW'(pop);
    end
  end

  assign m_axis_tvalid   = (count_q != '0);
  assign m_axis_tdata    = fifo_q[rptr_q].sym;
  assign m_axis_tlast    = fifo_q[rptr_q].last;
  assign m_axis_tuser[0] = fifo_q[rptr_q].not_found;

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pfc_pkg::ST_IDLE: begin
        if (cipher_start) begin
          state_d = pfc_pkg::ST_LOCATE;
        end
      end
      pfc_pkg::ST_LOCATE: begin
        state_d = pfc_pkg::ST_CALC;
      end
      pfc_pkg::ST_CALC: begin
        state_d = pfc_pkg::ST_RESULT;
      end
      pfc_pkg::ST_RESULT: begin
        if (push) begin
          state_d = pfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfc_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks.
  `PFC_ASSERT_IMP(a_queue_bound, clk_i, rst_ni, 1'b1, count_q <= NW'(FIFO_DEPTH))
  `PFC_ASSERT_NXT(a_cipher_locates, clk_i, rst_ni, cipher_start, state_q == pfc_pkg::ST_LOCATE)
  `PFC_ASSERT_IMP(a_not_found_item, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == '0) && m_axis_tlast)
  `PFC_ASSERT_NXT(a_result_done, clk_i, rst_ni, push, (state_q == pfc_pkg::ST_IDLE) && (count_q != '0 || $past(item_n) == 2'd0))

endmodule

// File: tb/pfc_checker.sv
// Result checker for the playfair digraph cipher: it watches the request, result and filler
// channels, predicts the symbols of every cipher request and compares them in order.
// Depends on pfc_pkg for the command codes, the result layout and the filler reset value.
module pfc_checker #(
  parameter int ROWS = pfc_pkg::ROWS_DEFAULT,
  parameter int COLS = pfc_pkg::COLS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // [4:0] entry_index, [20:5] first_symbol, [36:21] second_symbol, [39:37] zero
  input  logic [39:0] s_axis_tdata,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_symbol
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  // [0] not_found
  input  logic [0:0]  m_axis_tuser,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  input  logic        end_check_i,
  output int          pending_o,
  output int          failures_o
);

  localparam int TABLE_N = ROWS * COLS;

  // Shadow copy of the key table and the filler register.
  logic [pfc_pkg::SYM_W-1:0] key_copy [TABLE_N];
  logic [pfc_pkg::SYM_W-1:0] filler_copy;

  // Symbols still owed by the block, oldest first.
  pfc_pkg::out_item_t expected_syms [$];
  pfc_pkg::out_item_t want;
  bit                 end_done;

  // Prints one line for the mismatch and counts it.
  task automatic report_mismatch(input string what);
    failures_o++;
    $display("[%0t] cipher check: %s", $realtime, what);
  endtask

  // The position used is the first column in the last row that holds the symbol.
  function automatic bit locate_symbol(input logic [15:0] sym, output int row, output int col);
    bit found;
    bit row_hit;
    found = 1'b0;
    row = 0;
    col = 0;
    for (int r = 0; r < ROWS; r++) begin
      row_hit = 1'b0;
      for (int c = 0; c < COLS; c++) begin
        if (!row_hit && key_copy[r * COLS + c] == sym) begin
          row_hit = 1'b1;
          row = r;
          col = c;
          found = 1'b1;
        end
      end
    end
    return found;
  endfunction

  // Updates the shadow table for a load, or queues the symbols a cipher pair yields.
  task automatic apply_request(input pfc_pkg::cmd_e cmd, input int idx,
                               input logic [15:0] a, input logic [15:0] b);
    int r1, c1, r2, c2, p1, p2;
    bit hit1, hit2, dec, keep1, keep2;
    logic [15:0] s1, s2;
    pfc_pkg::out_item_t item;
    case (cmd)
      pfc_pkg::CMD_LOAD: begin
        if (idx < TABLE_N) key_copy[idx] = a;
      end
      pfc_pkg::CMD_ENCRYPT, pfc_pkg::CMD_DECRYPT: begin
        dec = (cmd == pfc_pkg::CMD_DECRYPT);
        hit1 = locate_symbol(a, r1, c1);
        hit2 = locate_symbol(b, r2, c2);
        if (!(hit1 && hit2)) begin
          // A missing symbol gives a single flagged zero result.
          item.sym = '0;
          item.last = 1'b1;
          item.not_found = 1'b1;
          expected_syms.push_back(item);
        end else begin
          if (r1 == r2) begin
            p1 = r1 * COLS + (c1 + (dec ? COLS - 1 : 1)) % COLS;
            p2 = r2 * COLS + (c2 + (dec ? COLS - 1 : 1)) % COLS;
          end else if (c1 == c2) begin
            p1 = ((r1 + (dec ? ROWS - 1 : 1)) % ROWS) * COLS + c1;
            p2 = ((r2 + (dec ? ROWS - 1 : 1)) % ROWS) * COLS + c2;
          end else begin
            p1 = r1 * COLS + c2;
            p2 = r2 * COLS + c1;
          end
          s1 = key_copy[p1];
          s2 = key_copy[p2];
          // Decryption drops padding symbols; the last symbol kept carries tlast.
          keep1 = !(dec && s1 == filler_copy);
          keep2 = !(dec && s2 == filler_copy);
          item.not_found = 1'b0;
          if (keep1) begin
            item.sym = s1;
            item.last = !keep2;
            expected_syms.push_back(item);
          end
          if (keep2) begin
            item.sym = s2;
            item.last = 1'b1;
            expected_syms.push_back(item);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // All three channels are sampled at the rising edge; results are checked in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filler_copy = pfc_pkg::FILLER_RESET;
      foreach (key_copy[p]) key_copy[p] = '0;
      expected_syms.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_syms.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h last %b not_found %b",
                                    m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
        end else begin
          want = expected_syms.pop_front();
          if (m_axis_tdata !== want.sym || m_axis_tlast !== want.last ||
              m_axis_tuser[0] !== want.not_found) begin
            report_mismatch($sformatf("got %h last %b not_found %b, wanted %h last %b not_found %b",
                                      m_axis_tdata, m_axis_tlast, m_axis_tuser[0],
                                      want.sym, want.last, want.not_found));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        apply_request(pfc_pkg::cmd_e'(s_axis_tuser), int'(s_axis_tdata[4:0]),
                      s_axis_tdata[20:5], s_axis_tdata[36:21]);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        filler_copy = cfg_data_i;
      end
      // At the end of the run nothing may still be owed.
      if (end_check_i && !end_done) begin
        end_done = 1'b1;
        if (expected_syms.size() != 0) begin
          report_mismatch($sformatf("%0d expected results never arrived", expected_syms.size()));
        end
      end
      pending_o = expected_syms.size();
    end
  end

endmodule

// File: tb/tb_playfair_digraph_cipher.sv
// Testbench top for the playfair digraph cipher: drives load, cipher and filler requests
// with random gaps and back-pressure, and gives the verdict from the checker's failure count.
// Depends on pfc_pkg, the playfair_digraph_cipher RTL and pfc_checker.
module tb_playfair_digraph_cipher;

  localparam int ROWS = pfc_pkg::ROWS_DEFAULT;
  localparam int COLS = pfc_pkg::COLS_DEFAULT;
  localparam int TABLE_N = ROWS * COLS;
  localparam int IDX_MAX = (1 << pfc_pkg::IDX_W) - 1;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 125;
  localparam logic [15:0] DUP_SYM = 16'hABCD;
  localparam logic [15:0] MISSING_SYM = 16'h7777;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [0:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        end_check;

  // Table contents as loaded, used to pick symbols that will be found.
  logic [15:0] key_table [TABLE_N];
  bit          no_idle;
  int          hold_trigger;
  int          pending;
  int          failures;

  playfair_digraph_cipher #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  pfc_checker #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .end_check_i  (end_check),
    .pending_o    (pending),
    .failures_o   (failures)
  );

  // Free-running clock, period 12.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4800000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result sink: random stalls, plus one long hold-off whenever the stimulus asks for one.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 16);
      end
    end
  end

  function automatic int pos(input int row, input int col);
    return row * COLS + col;
  endfunction

  function automatic logic [15:0] pick_symbol();
    return key_table[$urandom_range(TABLE_N - 1)];
  endfunction

  function automatic pfc_pkg::cmd_e random_cipher_cmd();
    return $urandom_range(1) ? pfc_pkg::CMD_DECRYPT : pfc_pkg::CMD_ENCRYPT;
  endfunction

  // Offers one request after a random gap and returns at the edge that accepts it.
  task automatic send_item(input pfc_pkg::cmd_e cmd, input int idx,
                           input logic [15:0] a, input logic [15:0] b);
    logic [pfc_pkg::IDX_W-1:0] idx_bits;
    idx_bits = idx[pfc_pkg::IDX_W-1:0];
    while (!no_idle && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, b, a, idx_bits};
    s_axis_tuser <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Waits until every owed result has arrived and the pipeline has emptied.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_filler(input logic [15:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Loads every entry of key_table, in a shuffled order.
  task automatic load_key_table();
    int order [TABLE_N];
    int j;
    int t;
    foreach (order[p]) order[p] = p;
    for (int p = TABLE_N - 1; p > 0; p--) begin
      j = $urandom_range(p);
      t = order[p];
      order[p] = order[j];
      order[j] = t;
    end
    foreach (order[p]) begin
      send_item(pfc_pkg::CMD_LOAD, order[p], key_table[order[p]], 16'($urandom));
    end
  endtask

  // Directed table: distinct symbols, both extremes, a duplicate and two filler entries.
  task automatic plan_directed_table();
    foreach (key_table[p]) key_table[p] = 16'(16'h1000 + p * 16'h0111);
    key_table[pos(0, 0)] = 16'h0000;
    key_table[pos(ROWS - 1, COLS - 1)] = 16'hFFFF;
    key_table[pos(1, 1)] = DUP_SYM;
    key_table[pos(2, 4)] = DUP_SYM;
    key_table[pos(2, 6)] = DUP_SYM;
    key_table[pos(0, 2)] = pfc_pkg::FILLER_RESET;
    key_table[pos(1, 5)] = pfc_pkg::FILLER_RESET;
  endtask

  // Random table: wide random symbols or a small alphabet full of duplicates, plus the filler at two random positions.
  task automatic plan_key_table(input bit narrow, input logic [15:0] fill);
    logic [15:0] alphabet [24];
    int span;
    span = $urandom_range(6, 24);
    foreach (alphabet[k]) alphabet[k] = 16'($urandom);
    foreach (key_table[p]) begin
      key_table[p] = narrow ? alphabet[$urandom_range(span - 1)] : 16'($urandom);
    end
    repeat (2) key_table[$urandom_range(TABLE_N - 1)] = fill;
  endtask

  // Mostly pairs drawn from the table, with absent symbols, reloads and no-ops mixed in.
  task automatic run_random_item();
    int roll;
    int idx;
    logic [15:0] a;
    logic [15:0] b;
    roll = $urandom_range(99);
    if (roll < 80) begin
      send_item(random_cipher_cmd(), $urandom_range(IDX_MAX), pick_symbol(), pick_symbol());
    end else if (roll < 88) begin
      a = pick_symbol();
      b = 16'($urandom);
      if ($urandom_range(1)) send_item(random_cipher_cmd(), $urandom_range(IDX_MAX), a, b);
      else send_item(random_cipher_cmd(), $urandom_range(IDX_MAX), b, a);
    end else if (roll < 94) begin
      idx = $urandom_range(TABLE_N - 1);
      a = $urandom_range(1) ? pick_symbol() : 16'($urandom);
      key_table[idx] = a;
      send_item(pfc_pkg::CMD_LOAD, idx, a, 16'($urandom));
    end else if (roll < 97) begin
      send_item(pfc_pkg::CMD_NOP, $urandom_range(IDX_MAX), 16'($urandom), 16'($urandom));
    end else begin
      send_item(random_cipher_cmd(), $urandom_range(IDX_MAX), 16'($urandom), 16'($urandom));
    end
  endtask

  // Main stimulus: reset, directed requests, then random phases under changing fillers.
  initial begin : stimulus
    logic [15:0] fill;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= pfc_pkg::CMD_NOP;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    end_check <= 1'b0;
    no_idle = 1'b0;
    hold_trigger = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan_directed_table();
    load_key_table();
    // Same row, wrapping past the last column and past the first.
    send_item(pfc_pkg::CMD_ENCRYPT, 0, key_table[pos(0, COLS - 1)], key_table[pos(0, 1)]);
    send_item(pfc_pkg::CMD_DECRYPT, IDX_MAX, key_table[pos(1, 0)], key_table[pos(1, 3)]);
    // Same column, wrapping past the bottom row and past the top.
    send_item(pfc_pkg::CMD_ENCRYPT, 0, key_table[pos(ROWS - 1, 4)], key_table[pos(0, 4)]);
    send_item(pfc_pkg::CMD_DECRYPT, 0, key_table[pos(0, 1)], key_table[pos(2, 1)]);
    // Rectangle between the extreme symbols.
    send_item(pfc_pkg::CMD_ENCRYPT, 0, 16'h0000, 16'hFFFF);
    send_item(pfc_pkg::CMD_DECRYPT, 0, 16'hFFFF, 16'h0000);
    // Identical symbols, and a symbol held in several rows.
    send_item(pfc_pkg::CMD_ENCRYPT, 0, key_table[pos(2, 3)], key_table[pos(2, 3)]);
    send_item(pfc_pkg::CMD_DECRYPT, 0, DUP_SYM, DUP_SYM);
    send_item(pfc_pkg::CMD_ENCRYPT, 0, DUP_SYM, key_table[pos(0, 3)]);
    // Symbols absent from the table.
    send_item(pfc_pkg::CMD_ENCRYPT, 0, MISSING_SYM, key_table[pos(0, 3)]);
    send_item(pfc_pkg::CMD_DECRYPT, 0, key_table[pos(0, 3)], MISSING_SYM);
    send_item(pfc_pkg::CMD_DECRYPT, 0, MISSING_SYM, ~MISSING_SYM);
    // Filler on both outputs, on the first only and on the second only.
    send_item(pfc_pkg::CMD_DECRYPT, 0, key_table[pos(0, 5)], key_table[pos(1, 2)]);
    send_item(pfc_pkg::CMD_ENCRYPT, 0, key_table[pos(0, 5)], key_table[pos(1, 2)]);
    send_item(pfc_pkg::CMD_DECRYPT, 0, key_table[pos(0, 3)], key_table[pos(1, 2)]);
    send_item(pfc_pkg::CMD_DECRYPT, 0, key_table[pos(ROWS - 1, 2)], key_table[pos(0, 0)]);
    send_item(pfc_pkg::CMD_NOP, IDX_MAX, 16'hFFFF, 16'hFFFF);

    // Random phases; the filler is only rewritten once the block has gone idle.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: fill = 16'h0000;
        1: fill = 16'hFFFF;
        2: fill = pfc_pkg::FILLER_RESET;
        default: fill = 16'($urandom);
      endcase
      settle();
      write_filler(fill);
      plan_key_table(ph % 2 == 1, fill);
      no_idle = (ph == 3);
      load_key_table();
      // One phase runs against a long receiver hold-off so the input side backs up.
      if (ph == 2) hold_trigger++;
      repeat (PHASE_ITEMS) run_random_item();
    end
    no_idle = 1'b0;

    settle();
    end_check <= 1'b1;
    @(posedge clk_i);
    @(posedge clk_i);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_lane.sv
hw/rtl/pfc_merge.sv
hw/rtl/pfc_table_ram.sv
hw/rtl/playfair_digraph_cipher.sv
tb/pfc_checker.sv
tb/tb_playfair_digraph_cipher.sv
